[hw/rtl/rsi_pkg.sv]
// shared types and constants of the ray-sphere intersection pipeline
package rsi_pkg;

	localparam int SqrtBits = 37;   // root bits, one per square root stage
	localparam int RemW     = 74;   // width of a non-negative discriminant
	localparam int BW       = 37;   // width of b, signed with 16 fraction bits (Q20.16)

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;
	localparam logic [1:0] REG_RADIUS   = 2'd3;

	typedef struct packed {
		logic signed [17:0] dir_z;
		logic signed [17:0] dir_y;
		logic signed [17:0] dir_x;
		logic signed [31:0] origin_z;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_x;
	} ray_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]        radius;
	} cfg_t;

	typedef struct packed {
		logic signed [BW-1:0] b;
		logic [RemW-1:0]      rem;
		logic                 miss;
	} disc_t;

endpackage

[hw/rtl/rsi_cfg.sv]
// sphere configuration registers behind the apb port
module rsi_cfg import rsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [31:0] cx_q, cy_q, cz_q;
	logic [30:0] r_q;
	logic [1:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			r_q  <= 31'd65536;
		end else if (wr) begin
			unique case (idx)
				REG_CENTER_X: cx_q <= pwdata;
				REG_CENTER_Y: cy_q <= pwdata;
				REG_CENTER_Z: cz_q <= pwdata;
				REG_RADIUS:   r_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_X: prdata = cx_q;
			REG_CENTER_Y: prdata = cy_q;
			REG_CENTER_Z: prdata = cz_q;
			REG_RADIUS:   prdata = {1'b0, r_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.center_x = $signed(cx_q);
	assign cfg.center_y = $signed(cy_q);
	assign cfg.center_z = $signed(cz_q);
	assign cfg.radius   = r_q;

endmodule

[hw/rtl/rsi_front.sv]
// front stages: offset, dot product, squares and discriminant
module rsi_front import rsi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  ray_t  ray,
	input  cfg_t  cfg,
	output logic  out_vld,
	output disc_t out
);

	// stage 1: oc = origin - centre
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [32:0] oc_s1 [3];
	logic signed [17:0] d_s1 [3];
	logic [30:0]        r_s1;

	// stage 2: products
	logic signed [50:0] dp_s2 [3];
	logic [33:0]        hh_s2 [3];
	logic [32:0]        hl_s2 [3];
	logic [31:0]        ll_s2 [3];
	logic [61:0]        rr_s2;

	// stage 3: sums
	logic signed [52:0] b32_s3;
	logic [65:0]        ocsq_s3;
	logic [61:0]        rr_s3;

	// stage 4: b and partial squares of b
	logic signed [BW-1:0] b_s4;
	logic [41:0]          bhh_s4;
	logic [36:0]          bhl_s4;
	logic [31:0]          bll_s4;
	logic signed [67:0]   t_s4;

	disc_t out_s5;

	logic [32:0]       oc_abs [3];
	logic [BW-1:0]     b_abs;
	logic signed [BW-1:0] b16;
	logic [RemW-1:0]   bsq;
	logic signed [RemW:0] disc;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			oc_abs[i] = oc_s1[i][32] ? 33'(~oc_s1[i] + 33'sd1) : oc_s1[i];
		end
		b16   = b32_s3[52:16];   // floor of value / 2^16
		b_abs = b16[BW-1] ? BW'(~b16 + 1'b1) : b16;
		bsq   = (RemW'(bhh_s4) << 32) + (RemW'(bhl_s4) << 17) + RemW'(bll_s4);
		disc  = $signed({1'b0, bsq}) + (RemW+1)'(t_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oc_s1[0] <= 33'(ray.origin_x) - 33'(cfg.center_x);
			oc_s1[1] <= 33'(ray.origin_y) - 33'(cfg.center_y);
			oc_s1[2] <= 33'(ray.origin_z) - 33'(cfg.center_z);
			d_s1[0]  <= ray.dir_x;
			d_s1[1]  <= ray.dir_y;
			d_s1[2]  <= ray.dir_z;
			r_s1     <= cfg.radius;

			for (int i = 0; i < 3; i++) begin
				dp_s2[i] <= d_s1[i] * oc_s1[i];
				hh_s2[i] <= oc_abs[i][32:16] * oc_abs[i][32:16];
				hl_s2[i] <= oc_abs[i][32:16] * oc_abs[i][15:0];
				ll_s2[i] <= oc_abs[i][15:0] * oc_abs[i][15:0];
			end
			rr_s2 <= r_s1 * r_s1;

			b32_s3 <= 53'(dp_s2[0]) + 53'(dp_s2[1]) + 53'(dp_s2[2]);
			ocsq_s3 <= (66'(hh_s2[0]) << 32) + (66'(hl_s2[0]) << 17) + 66'(ll_s2[0])
				+ (66'(hh_s2[1]) << 32) + (66'(hl_s2[1]) << 17) + 66'(ll_s2[1])
				+ (66'(hh_s2[2]) << 32) + (66'(hl_s2[2]) << 17) + 66'(ll_s2[2]);
			rr_s3 <= rr_s2;

			b_s4   <= b16;
			bhh_s4 <= b_abs[36:16] * b_abs[36:16];
			bhl_s4 <= b_abs[36:16] * b_abs[15:0];
			bll_s4 <= b_abs[15:0] * b_abs[15:0];
			t_s4   <= $signed({6'b0, rr_s3}) - $signed({2'b0, ocsq_s3});

			out_s5.b    <= b_s4;
			out_s5.miss <= disc[RemW];
			out_s5.rem  <= disc[RemW] ? '0 : disc[RemW-1:0];
		end
	end

	assign out_vld = vld_s5;
	assign out     = out_s5;

endmodule

[hw/rtl/rsi_sqrt.sv]
// pipelined integer square root, one root bit per stage
module rsi_sqrt import rsi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  disc_t               in,
	output logic                out_vld,
	output disc_t               out,
	output logic [SqrtBits-1:0] root
);

	logic                vld_s  [SqrtBits];
	disc_t               pipe_s [SqrtBits];
	logic [SqrtBits-1:0] root_s [SqrtBits];

	for (genvar j = 0; j < SqrtBits; j++) begin : g_stage
		localparam int K = SqrtBits - 1 - j;
		logic                vin;
		disc_t               din;
		logic [SqrtBits-1:0] rin;
		logic [RemW+1:0]     trial;
		logic                ge;

		if (j == 0) begin : g_first
			assign vin = in_vld;
			assign din = in;
			assign rin = '0;
		end else begin : g_next
			assign vin = vld_s[j-1];
			assign din = pipe_s[j-1];
			assign rin = root_s[j-1];
		end

		// rem holds x - root^2; try setting bit K
		assign trial = ((RemW+2)'(rin) << (K+1)) + ((RemW+2)'(1) << (2*K));
		assign ge    = {2'b0, din.rem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[j].b    <= din.b;
				pipe_s[j].miss <= din.miss;
				pipe_s[j].rem  <= ge ? RemW'({2'b0, din.rem} - trial) : din.rem;
				root_s[j]      <= ge ? (rin | (SqrtBits'(1) << K)) : rin;
			end
		end
	end

	assign out_vld = vld_s[SqrtBits-1];
	assign out     = pipe_s[SqrtBits-1];
	assign root    = root_s[SqrtBits-1];

endmodule

[hw/rtl/ray_sphere_intersect.sv]
// top level of the ray-sphere intersection pipeline
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+----------------------------------
//  s_*       | in        | s_tvalid / s_tready      | one ray request per beat
//  m_*       | out       | m_tvalid / m_tready      | hit flag in tuser, distance in tdata
//  apb       | in/out    | psel, penable, pready    | centre x/y/z at 0x0/0x4/0x8, radius 0xc
//
// one ray is accepted every cycle unless the result side stalls; a request passes
// 5 front stages, 37 square root stages and 1 output stage on its way to the result;
// the square root is one root bit per stage, which sets the depth
// reset clears all valid bits and loads centre 0 and radius 1.0
// a stall on the result side freezes every stage at once; s_tready drops only
// while a result is held and m_tready is low
module ray_sphere_intersect import rsi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// ray request
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up, 2 unused top bits
	input  logic [151:0] s_tdata,
	// result
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance
	output logic [31:0]  m_tdata,
	// hit
	output logic [0:0]   m_tuser,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t                cfg;
	ray_t                ray;
	logic                en;
	logic                disc_vld, sq_vld;
	disc_t               disc, sq;
	logic [SqrtBits-1:0] root;

	logic                out_vld_q;
	logic                hit_q;
	logic [31:0]         dist_q;

	// roots of the quadratic, wide enough for -b +/- s
	logic signed [BW+1:0] neg_b, near_r, far_r, t_sel;
	logic                 hit_c;

	// whole pipeline moves unless a held result is not taken
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	assign ray = ray_t'(s_tdata[149:0]);

	rsi_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	rsi_front u_front (
		.clk, .arst_n, .en,
		.in_vld  (s_tvalid),
		.ray,
		.cfg,
		.out_vld (disc_vld),
		.out     (disc)
	);

	rsi_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_vld  (disc_vld),
		.in      (disc),
		.out_vld (sq_vld),
		.out     (sq),
		.root
	);

	// pick the nearest strictly positive root, far root when the origin is inside
	always_comb begin
		neg_b  = -(BW+2)'(sq.b);
		near_r = neg_b - $signed({2'b0, root});
		far_r  = neg_b + $signed({2'b0, root});
		hit_c  = 1'b0;
		t_sel  = '0;
		if (!sq.miss) begin
			if (near_r > 0) begin
				hit_c = 1'b1;
				t_sel = near_r;
			end else if (far_r > 0) begin
				hit_c = 1'b1;
				t_sel = far_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_c;
			if (!hit_c) begin
				dist_q <= '0;
			end else if (t_sel[BW+1:32] != '0) begin
				dist_q <= '1;   // saturate
			end else begin
				dist_q <= t_sel[31:0];
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = dist_q;
	assign m_tuser  = hit_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss with nonzero distance");

	a_hit_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata != '0))
		else $error("hit with zero distance");

	a_stall_holds_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sq_vld))
		else $error("square root stage moved during stall");

endmodule
